### src/tpps_pkg.sv
// ----------------------------------------------------------------------------
// tpps_pkg
// Shared types, register codes and reset values of the two-path scheduler.
// ----------------------------------------------------------------------------
package tpps_pkg;

   localparam int MAX_PATHS_DEF = 8;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_SEG    = 2'd1;
   localparam logic [1:0] CSR_LSTART = 2'd2;
   localparam logic [1:0] CSR_LSTEP  = 2'd3;

   localparam logic [1:0] MODE_RR    = 2'd0;
   localparam logic [1:0] MODE_MINRTT = 2'd1;
   localparam logic [1:0] MODE_BLEST = 2'd2;
   localparam logic [1:0] MODE_ECF   = 2'd3;

   localparam logic [1:0]  MODE_RST   = MODE_MINRTT;
   localparam logic [15:0] SEG_RST    = 16'd1460;
   localparam logic [15:0] LSTART_RST = 16'd1000;
   localparam logic [15:0] LSTEP_RST  = 16'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_C,
      ST_MUL_CF,
      ST_MUL_MSS,
      ST_MUL_S,
      ST_MUL_LAM,
      ST_MUL_R1,
      ST_MUL_R2,
      ST_DIV_Q1,
      ST_MUL_NF,
      ST_DIV_Q2,
      ST_MUL_QS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         start;
      logic [127:0] x;
      logic [31:0]  y;
      logic [5:0]   nbits;
   } mul_cmd_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

### src/tpps_mul.sv
// ----------------------------------------------------------------------------
// tpps_mul
// Shift-add multiplier: wide operand times up to 32 bits, one bit a cycle.
// ----------------------------------------------------------------------------
module tpps_mul
   import tpps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mul_cmd_type  cmd,
   output unit_sts_type sts,
   output logic [127:0] prod
);

   logic [127:0] x_ff, x_in, acc_ff, acc_in;
   logic [31:0]  y_ff, y_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = cmd.x;
         y_in    = cmd.y;
         acc_in  = '0;
         cnt_in  = cmd.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (y_ff[0] ? x_ff : 128'd0);
         x_in   = {x_ff[126:0], 1'b0};
         y_in   = {1'b0, y_ff[31:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign prod     = acc_ff;

endmodule

### src/tpps_div.sv
// ----------------------------------------------------------------------------
// tpps_div
// Restoring 32 by 32 bit divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tpps_div
   import tpps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output unit_sts_type sts,
   output logic [31:0]  quot
);

   logic [31:0] q_ff, q_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[31]};
      if (cmd.start) begin
         q_in    = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 32'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = q_ff;

endmodule

### src/two_path_packet_scheduler_top.sv
// ----------------------------------------------------------------------------
// two_path_packet_scheduler_top
// Per-packet path choice: round robin, min RTT, BLEST or ECF.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one send decision request; req_ready is high only while
//    the sequencer is idle, so one request is in work at a time.
//  - rsp_* returns the chosen path through an output register; the next
//    request is taken while an earlier answer still waits for rsp_ready.
//  - csr_* writes mode, segment size, lambda start and lambda step; it is
//    always ready. Writing lambda start also reloads the running lambda.
// Decision paths (accept to rsp_valid):
//  - trivial cases (no/one path, round robin, unknown RTT, fast path has
//    room, min RTT, BLEST with negative buffer room and nonzero fast RTT)
//    are decided in the idle state.
//  - ECF: one or two divides and multiplies.
//  - BLEST: one divide and up to six multiplies.
//  Both use the shared divider and the shift-add multiplier (one
//  multiplier bit per cycle, 16 or 24 bits per product).
//  A new request is taken once the previous answer enters the output register.
// Reset: synchronous, restores register defaults, clears last path and the
//  ECF waiting flag, loads lambda start into the running lambda.
// Stall: a finished decision holds in the done state until the output
//  register is free; nothing is dropped.
// ----------------------------------------------------------------------------
module two_path_packet_scheduler_top
   import tpps_pkg::*;
#(
   parameter int MAX_PATHS = MAX_PATHS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_path_count,
   input  logic [23:0] req_rtt_first,
   input  logic [23:0] req_rtt_second,
   input  logic [23:0] req_rtt_var_first,
   input  logic [23:0] req_rtt_var_second,
   input  logic [1:0]  req_room_mask,
   input  logic [31:0] req_cwnd_first,
   input  logic [31:0] req_cwnd_second,
   input  logic [31:0] req_inflight_first,
   input  logic [31:0] req_inflight_second,
   input  logic [31:0] req_tx_free,
   input  logic [31:0] req_buffered_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_chosen_path,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // path count saturates at MAX_PATHS, at most 15 (input field is 4 bits wide)
   localparam int         CLAMP   = (MAX_PATHS < 15) ? MAX_PATHS : 15;
   localparam logic [3:0] CLAMP_V = 4'(CLAMP);

   state_type state_ff, state_in;

   // config and scheduler state
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] seg_ff, seg_in, lstart_ff, lstart_in, lstep_ff, lstep_in;
   logic [15:0] lam_ff, lam_in;
   logic [2:0]  last_ff, last_in;
   logic        wait_ff, wait_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_path_ff, rsp_path_in;

   // per-request working registers
   logic [2:0]   choice_ff, choice_in;
   logic         upd_ff, upd_in;
   logic         fast_ff, fast_in;
   logic [23:0]  f_ff, f_in, s_ff, s_in, d_ff, d_in;
   logic [31:0]  cwf_ff, cwf_in, cws_ff, cws_in, buf_ff, buf_in;
   logic [15:0]  mss_ff, mss_in;
   logic [34:0]  comp_ff, comp_in;
   logic [63:0]  a_ff, a_in;
   logic [127:0] lhs_ff, lhs_in;

   // shared units
   mul_cmd_type  mul_cmd;
   div_cmd_type  div_cmd;
   unit_sts_type mul_sts, div_sts;
   logic [127:0] mul_p;
   logic [31:0]  div_q;

   // request-side decode
   logic [3:0]  cnt_eff, rr;
   logic        slow0, fast;
   logic [31:0] cw0, cw1;
   logic [15:0] mss;
   logic [2:0]  ch_fast, ch_slow;
   logic [25:0] ecf_lim, ecf_thr;

   tpps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .sts   (mul_sts),
      .prod  (mul_p)
   );

   tpps_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts),
      .quot  (div_q)
   );

   always_comb begin
      cnt_eff = (req_path_count > CLAMP_V) ? CLAMP_V : req_path_count;
      // (last + 1) mod count, count >= 2 and last + 1 <= 8
      rr = {1'b0, last_ff} + 4'd1;
      for (int i = 0; i < 4; i++) begin
         if (rr >= cnt_eff) rr = rr - cnt_eff;
      end
      slow0 = (mode_ff == MODE_MINRTT) ? (req_rtt_first >= req_rtt_second)
                                       : (req_rtt_first > req_rtt_second);
      fast = slow0;
      cw0  = (req_cwnd_first == 32'd0) ? 32'd1 : req_cwnd_first;
      cw1  = (req_cwnd_second == 32'd0) ? 32'd1 : req_cwnd_second;
      mss  = (seg_ff == 16'd0) ? 16'd1 : seg_ff;
      ch_fast = {2'b00, fast_ff};
      ch_slow = {2'b00, ~fast_ff};
      ecf_lim = {1'b0, {1'b0, s_ff} + {1'b0, d_ff}} << wait_ff;
      ecf_thr = {1'b0, f_ff, 1'b0} + {2'b00, d_ff};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      seg_in       = seg_ff;
      lstart_in    = lstart_ff;
      lstep_in     = lstep_ff;
      lam_in       = lam_ff;
      last_in      = last_ff;
      wait_in      = wait_ff;
      rsp_path_in  = rsp_path_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      choice_in    = choice_ff;
      upd_in       = upd_ff;
      fast_in      = fast_ff;
      f_in         = f_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      cwf_in       = cwf_ff;
      cws_in       = cws_ff;
      buf_in       = buf_ff;
      mss_in       = mss_ff;
      comp_in      = comp_ff;
      a_in         = a_ff;
      lhs_in       = lhs_ff;
      mul_cmd      = '0;
      div_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fast_in = fast;
               f_in    = fast ? req_rtt_second : req_rtt_first;
               s_in    = fast ? req_rtt_first : req_rtt_second;
               d_in    = (req_rtt_var_first > req_rtt_var_second) ?
                         req_rtt_var_first : req_rtt_var_second;
               cwf_in  = fast ? cw1 : cw0;
               cws_in  = fast ? cw0 : cw1;
               buf_in  = req_buffered_bytes;
               mss_in  = mss;
               comp_in = {3'b000, req_tx_free}
                       - {3'b000, fast ? req_inflight_first : req_inflight_second}
                       - {19'd0, mss};
               upd_in  = (cnt_eff != 4'd0);
               state_in = ST_DONE;
               if (cnt_eff <= 4'd1) begin
                  choice_in = 3'd0;
               end else if (mode_ff == MODE_RR) begin
                  choice_in = rr[2:0];
               end else if (req_rtt_second == 24'd0) begin
                  choice_in = (mode_ff == MODE_ECF) ? rr[2:0] : 3'd1;
               end else if (req_room_mask[fast]) begin
                  choice_in = {2'b00, fast};
               end else if (mode_ff == MODE_MINRTT) begin
                  choice_in = {2'b00, ~fast};
               end else if (mode_ff == MODE_BLEST) begin
                  lam_in = lam_ff + lstep_ff;
                  // negative buffer room with a nonzero fast RTT always waits
                  if (comp_in[34] && (f_in != 24'd0)) begin
                     choice_in = {2'b00, fast};
                  end else begin
                     state_in = ST_DIV_C;
                  end
               end else begin
                  state_in = ST_DIV_Q1;
               end
            end
         end
         ST_DIV_C: begin
            div_cmd.start    = !div_sts.busy && !div_sts.done;
            div_cmd.dividend = cwf_ff;
            div_cmd.divisor  = {16'd0, mss_ff};
            if (div_sts.done) state_in = ST_MUL_CF;
         end
         ST_MUL_CF: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = {96'd0, div_q};
            mul_cmd.y     = {8'd0, f_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) begin
               a_in     = {mul_p[62:0], 1'b0} + {40'd0, s_ff - f_ff};
               state_in = ST_MUL_MSS;
            end
         end
         ST_MUL_MSS: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = {64'd0, a_ff};
            mul_cmd.y     = {16'd0, mss_ff};
            mul_cmd.nbits = 6'd16;
            if (mul_sts.done) state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = mul_p;
            mul_cmd.y     = {8'd0, s_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) state_in = ST_MUL_LAM;
         end
         ST_MUL_LAM: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = mul_p;
            mul_cmd.y     = {16'd0, lam_ff};
            mul_cmd.nbits = 6'd16;
            if (mul_sts.done) begin
               lhs_in = mul_p;
               if (comp_ff[34]) begin
                  // right side is zero here
                  choice_in = (mul_p != 128'd0) ? ch_fast : ch_slow;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_MUL_R1;
               end
            end
         end
         ST_MUL_R1: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = {96'd0, comp_ff[31:0]};
            mul_cmd.y     = {8'd0, f_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) state_in = ST_MUL_R2;
         end
         ST_MUL_R2: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = mul_p;
            mul_cmd.y     = {8'd0, f_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) begin
               choice_in = (lhs_ff > {mul_p[126:0], 1'b0}) ? ch_fast : ch_slow;
               state_in  = ST_DONE;
            end
         end
         ST_DIV_Q1: begin
            div_cmd.start    = !div_sts.busy && !div_sts.done;
            div_cmd.dividend = buf_ff;
            div_cmd.divisor  = cwf_ff;
            if (div_sts.done) state_in = ST_MUL_NF;
         end
         ST_MUL_NF: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = {95'd0, {1'b0, div_q} + 33'd1};
            mul_cmd.y     = {8'd0, f_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) begin
               if (mul_p < {102'd0, ecf_lim}) begin
                  state_in = ST_DIV_Q2;
               end else begin
                  wait_in   = 1'b0;
                  choice_in = ch_slow;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DIV_Q2: begin
            div_cmd.start    = !div_sts.busy && !div_sts.done;
            div_cmd.dividend = buf_ff;
            div_cmd.divisor  = cws_ff;
            if (div_sts.done) state_in = ST_MUL_QS;
         end
         ST_MUL_QS: begin
            mul_cmd.start = !mul_sts.busy && !mul_sts.done;
            mul_cmd.x     = {96'd0, div_q};
            mul_cmd.y     = {8'd0, s_ff};
            mul_cmd.nbits = 6'd24;
            if (mul_sts.done) begin
               if (mul_p >= {102'd0, ecf_thr}) begin
                  wait_in   = 1'b1;
                  choice_in = ch_fast;
               end else begin
                  choice_in = ch_slow;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_path_in  = choice_ff;
               if (upd_ff) last_in = choice_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:   mode_in = csr_data[1:0];
            CSR_SEG:    seg_in  = csr_data;
            CSR_LSTART: begin
               lstart_in = csr_data;
               lam_in    = csr_data;
            end
            CSR_LSTEP:  lstep_in = csr_data;
            default:    mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RST;
         seg_ff       <= SEG_RST;
         lstart_ff    <= LSTART_RST;
         lstep_ff     <= LSTEP_RST;
         lam_ff       <= LSTART_RST;
         last_ff      <= 3'd0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         seg_ff       <= seg_in;
         lstart_ff    <= lstart_in;
         lstep_ff     <= lstep_in;
         lam_ff       <= lam_in;
         last_ff      <= last_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_path_ff <= rsp_path_in;
      choice_ff   <= choice_in;
      upd_ff      <= upd_in;
      fast_ff     <= fast_in;
      f_ff        <= f_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      cwf_ff      <= cwf_in;
      cws_ff      <= cws_in;
      buf_ff      <= buf_in;
      mss_ff      <= mss_in;
      comp_ff     <= comp_in;
      a_ff        <= a_in;
      lhs_ff      <= lhs_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_path = rsp_path_ff;

endmodule

### src/tpps_checker.sv
// ----------------------------------------------------------------------------
// tpps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tpps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_chosen_path,
   input logic       csr_ready
);

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_path))
      else $error("stalled response changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear handshake state");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind two_path_packet_scheduler_top tpps_checker u_tpps_checker (.*);
